>>> design/assert_macros.svh
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, active through reset as well
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/wmd_pkg.sv
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared widths, register indexes, reciprocal table and the command and
// status bundles between the decimator controller and datapath.
// ----------------------------------------------------------------------------
package wmd_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int FRAME_W         = 24;
  localparam int CHAN_W          = 4;
  localparam int CHAN_POS_W      = 3;
  localparam int COL_W           = 6;
  localparam int SUM_W           = 19;
  localparam int MAX_CHANNELS    = 8;
  localparam int DEFAULT_COLUMNS = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  localparam logic [FRAME_W-1:0] FRAME_COUNT_RST   = 24'd1;
  localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RST = 4'd1;

  localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 16'sh8000;

  // reciprocal of the channel count, ceil(2^RECIP_SHIFT / n), exact for |sum| <= 2^18
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int QUOT_W      = 17;

  function automatic logic [RECIP_W-1:0] recip(input logic [CHAN_POS_W-1:0] idx);
    logic [RECIP_W-1:0] r;
    case (idx)
      3'd0: r = 25'd16777216;
      3'd1: r = 25'd8388608;
      3'd2: r = 25'd5592406;
      3'd3: r = 25'd4194304;
      3'd4: r = 25'd3355444;
      3'd5: r = 25'd2796203;
      3'd6: r = 25'd2396746;
      default: r = 25'd2097152;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic accum;
    logic close;
    logic mul;
    logic quot;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_chan;
    logic emit_cond;
    logic out_free;
  } sts_t;

endpackage

>>> design/wmd_sample_if.sv
// ----------------------------------------------------------------------------
// wmd_sample_if
// Valid/ready channel carrying one interleaved Q1.15 audio sample.
// ----------------------------------------------------------------------------
interface wmd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wmd_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> design/wmd_column_if.sv
// ----------------------------------------------------------------------------
// wmd_column_if
// Valid/ready channel carrying one display column's min/max report.
// ----------------------------------------------------------------------------
interface wmd_column_if;
  logic                                 valid;
  logic                                 ready;
  logic [wmd_pkg::COL_W-1:0]            column;
  logic signed [wmd_pkg::SAMPLE_W-1:0]  low_value;
  logic signed [wmd_pkg::SAMPLE_W-1:0]  high_value;
  logic                                 final_column;

  modport source (output valid, output column, output low_value, output high_value,
                  output final_column, input ready);
  modport sink (input valid, input column, input low_value, input high_value,
                input final_column, output ready);
endinterface

>>> design/wmd_ctrl.sv
// ----------------------------------------------------------------------------
// wmd_ctrl
// Sequencer: takes samples, runs the two-step reciprocal divide at the end
// of a frame, then walks the column emission loop.
// ----------------------------------------------------------------------------
module wmd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wmd_pkg::sts_t sts,
  output wmd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    MUL  = 4'b0010,
    QUOT = 4'b0100,
    EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        // no transfer while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (sts.last_chan) begin
            cmd.close  = 1'b1;
            state_next = MUL;
          end else begin
            cmd.accum = 1'b1;
          end
        end
      end
      MUL: begin
        cmd.mul    = 1'b1;
        state_next = QUOT;
      end
      QUOT: begin
        cmd.quot   = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        if (sts.emit_cond) begin
          cmd.emit = sts.out_free;
        end else begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

>>> design/wmd_datapath.sv
// ----------------------------------------------------------------------------
// wmd_datapath
// Channel accumulator, reciprocal divider, running min/max, column boundary
// test by cross-multiplied compares, and the output register.
// ----------------------------------------------------------------------------
module wmd_datapath #(
  parameter int COLUMNS = wmd_pkg::DEFAULT_COLUMNS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [wmd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wmd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [wmd_pkg::SAMPLE_W-1:0]  sample,
  input  wmd_pkg::cmd_t                        cmd,
  output wmd_pkg::sts_t                        sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [wmd_pkg::COL_W-1:0]            out_column,
  output logic signed [wmd_pkg::SAMPLE_W-1:0]  out_low,
  output logic signed [wmd_pkg::SAMPLE_W-1:0]  out_high,
  output logic                                 out_final
);

  localparam int CNT_W   = $clog2(COLUMNS + 1);
  localparam int PROD_W  = wmd_pkg::FRAME_W + CNT_W + 1;
  localparam int DPROD_W = wmd_pkg::SUM_W + wmd_pkg::RECIP_W;

  logic [wmd_pkg::FRAME_W-1:0]           frame_count;
  logic [wmd_pkg::CHAN_W-1:0]            channel_count;
  logic [wmd_pkg::CHAN_POS_W-1:0]        chan_pos;
  logic signed [wmd_pkg::SUM_W-1:0]      chan_sum;
  logic                                  div_neg;
  logic [wmd_pkg::SUM_W-1:0]             div_mag;
  logic [wmd_pkg::CHAN_POS_W-1:0]        div_idx;
  logic [DPROD_W-1:0]                    div_prod;
  logic signed [wmd_pkg::SAMPLE_W-1:0]   avg;
  logic signed [wmd_pkg::SAMPLE_W-1:0]   run_min;
  logic signed [wmd_pkg::SAMPLE_W-1:0]   run_max;
  logic                                  first;
  logic [CNT_W-1:0]                      col_cnt;
  logic [wmd_pkg::FRAME_W-1:0]           frame_pos;
  logic [PROD_W-1:0]                     x_prod;
  logic [PROD_W-1:0]                     z_prod;

  logic [wmd_pkg::FRAME_W-1:0]           frames_eff;
  logic [wmd_pkg::CHAN_W-1:0]            chans_eff;
  logic signed [wmd_pkg::SUM_W-1:0]      sample_ext;
  logic signed [wmd_pkg::SUM_W-1:0]      sum_full;
  logic [wmd_pkg::QUOT_W-1:0]            quot_mag;
  logic signed [wmd_pkg::QUOT_W-1:0]     quot_sgn;
  logic signed [wmd_pkg::SAMPLE_W-1:0]   avg_new;
  logic [wmd_pkg::FRAME_W:0]             frame_plus1;
  logic [PROD_W-1:0]                     y_prod;
  logic [PROD_W-1:0]                     w_prod;
  logic                                  last_frame;
  logic                                  col_open;

  assign frames_eff = (frame_count == '0) ? wmd_pkg::FRAME_W'(1) : frame_count;

  always_comb begin
    if (channel_count == '0) begin
      chans_eff = wmd_pkg::CHAN_W'(1);
    end else if (channel_count > wmd_pkg::CHAN_W'(wmd_pkg::MAX_CHANNELS)) begin
      chans_eff = wmd_pkg::CHAN_W'(wmd_pkg::MAX_CHANNELS);
    end else begin
      chans_eff = channel_count;
    end
  end

  assign sample_ext = wmd_pkg::SUM_W'(sample);
  assign sum_full   = chan_sum + sample_ext;

  assign quot_mag = div_prod[wmd_pkg::RECIP_SHIFT +: wmd_pkg::QUOT_W];
  assign quot_sgn = div_neg ? -$signed(quot_mag) : $signed(quot_mag);
  assign avg_new  = quot_sgn[wmd_pkg::SAMPLE_W-1:0];

  // column c is due at frame f if f is last or (c+1)*F<(f+2)*C and c*F<(f+1)*C
  assign frame_plus1 = {1'b0, frame_pos} + (wmd_pkg::FRAME_W + 1)'(1);
  assign last_frame  = frame_plus1 >= {1'b0, frames_eff};
  assign y_prod      = x_prod + PROD_W'(frames_eff);
  assign w_prod      = z_prod + PROD_W'(COLUMNS);
  assign col_open    = col_cnt < CNT_W'(COLUMNS);

  assign sts.last_chan = ({1'b0, chan_pos} + wmd_pkg::CHAN_W'(1)) >= chans_eff;
  assign sts.emit_cond = col_open && (last_frame || ((y_prod < w_prod) && (x_prod < z_prod)));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= wmd_pkg::FRAME_COUNT_RST;
      channel_count <= wmd_pkg::CHANNEL_COUNT_RST;
      chan_pos      <= '0;
      chan_sum      <= '0;
      run_min       <= wmd_pkg::MIN_INIT;
      run_max       <= wmd_pkg::MAX_INIT;
      first         <= 1'b0;
      col_cnt       <= '0;
      frame_pos     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          wmd_pkg::CFG_FRAME_COUNT:   frame_count <= cfg_data[wmd_pkg::FRAME_W-1:0];
          wmd_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[wmd_pkg::CHAN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accum) begin
        chan_sum <= sum_full;
        chan_pos <= chan_pos + wmd_pkg::CHAN_POS_W'(1);
      end
      if (cmd.close) begin
        chan_sum <= '0;
        chan_pos <= '0;
      end
      if (cmd.quot) begin
        first <= 1'b1;
        if (avg_new < run_min) begin
          run_min <= avg_new;
        end
        if (avg_new > run_max) begin
          run_max <= avg_new;
        end
      end
      if (cmd.emit) begin
        col_cnt <= col_cnt + CNT_W'(1);
        first   <= 1'b0;
      end
      if (cmd.finish) begin
        if (!first || !col_open) begin
          run_min <= wmd_pkg::MIN_INIT;
          run_max <= wmd_pkg::MAX_INIT;
        end
        if (!col_open) begin
          col_cnt   <= '0;
          frame_pos <= '0;
        end else begin
          frame_pos <= frame_pos + wmd_pkg::FRAME_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      div_neg <= sum_full[wmd_pkg::SUM_W-1];
      div_mag <= sum_full[wmd_pkg::SUM_W-1] ? wmd_pkg::SUM_W'(-sum_full)
                                             : wmd_pkg::SUM_W'(sum_full);
      div_idx <= wmd_pkg::CHAN_POS_W'(chans_eff - wmd_pkg::CHAN_W'(1));
    end
    if (cmd.mul) begin
      div_prod <= DPROD_W'(div_mag) * DPROD_W'(wmd_pkg::recip(div_idx));
    end
    if (cmd.quot) begin
      avg    <= avg_new;
      x_prod <= PROD_W'(col_cnt) * PROD_W'(frames_eff);
      z_prod <= PROD_W'(frame_plus1) * PROD_W'(COLUMNS);
    end
    if (cmd.emit) begin
      x_prod     <= y_prod;
      out_column <= wmd_pkg::COL_W'(col_cnt);
      out_low    <= first ? run_min : avg;
      out_high   <= first ? run_max : avg;
      out_final  <= col_cnt == CNT_W'(COLUMNS - 1);
    end
  end

endmodule

>>> design/waveform_minmax_decimator_core.sv
// Min/max peak decimator for a waveform display.
// Input channel "samples" takes interleaved Q1.15 audio samples, one per
// transfer; each frame of channel_count samples is averaged (toward zero).
// Output channel "columns" gives one transfer per display column: its index,
// the min and max averaged sample and a flag on the last column of the clip.
// frame_count and channel_count are written on the cfg port; the user must
// write them only while idle, as the block itself does not enforce it. A
// sample that does not close a frame is accumulated into the channel sum. A
// frame-closing sample steps through accept, reciprocal multiply, quotient
// and boundary products, one emission per column that ends at that frame and
// loop exit; no new sample is taken before the loop exits.
// Results pass through an output register: the sampler side keeps taking
// input while a report waits. If the receiver stalls during emission, the
// loop holds until the register frees, and no sample is taken meanwhile.
// Reset (synchronous, active high) restores frame_count = channel_count = 1
// and starts the clip at frame 0, column 0; no sample is taken while it is
// high and no clearing pass is needed.
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// waveform_minmax_decimator_core
// Top level: controller, datapath and the channel/port wiring.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator_core #(
  parameter int COLUMNS = wmd_pkg::DEFAULT_COLUMNS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [wmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  wmd_sample_if.sink                      samples,
  wmd_column_if.source                    columns
);

  wmd_pkg::cmd_t cmd;
  wmd_pkg::sts_t sts;

  wmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wmd_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (samples.sample),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (columns.ready),
    .out_valid    (columns.valid),
    .out_column   (columns.column),
    .out_low      (columns.low_value),
    .out_high     (columns.high_value),
    .out_final    (columns.final_column)
  );

  `ASSERT_CLK_RST(a_emit_into_free_reg, clk, rst, cmd.emit |-> sts.out_free, "column loaded over a pending transfer")
  `ASSERT_CLK_RST(a_no_take_while_emit, clk, rst, cmd.emit |-> !samples.ready, "sample taken during column emission")
  `ASSERT_CLK_RST(a_final_is_last, clk, rst, (columns.valid && columns.final_column) |-> (columns.column == wmd_pkg::COL_W'(COLUMNS - 1)), "final flag on a column other than the last")
  `ASSERT_CLK(a_reset_clears_out, clk, rst |=> !columns.valid, "output valid after reset")

endmodule

>>> tb/sv/tb_waveform_minmax_decimator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_minmax_decimator_core
// Streams interleaved Q1.15 samples into the min/max decimator under several
// frame and channel count settings. A cycle-free model of the averaging and
// column boundaries predicts every column report. Each report is checked in
// order against that prediction while both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_waveform_minmax_decimator_core;
  import wmd_pkg::*;

  localparam int COLUMNS       = DEFAULT_COLUMNS;
  localparam int CLK_PERIOD    = 12;
  localparam int TIMEOUT_NS    = 1_000_000 * CLK_PERIOD;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 70;

  typedef struct packed {
    logic [COL_W-1:0]           column;
    logic signed [SAMPLE_W-1:0] low_value;
    logic signed [SAMPLE_W-1:0] high_value;
    logic                       final_column;
  } column_report_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wmd_sample_if samples_if ();
  wmd_column_if columns_if ();

  waveform_minmax_decimator_core #(
    .COLUMNS(COLUMNS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .samples     (samples_if),
    .columns     (columns_if)
  );

  // decimator state as predicted
  logic [FRAME_W-1:0] frame_count_reg;
  logic [CHAN_W-1:0]  channel_count_reg;
  int                 chan_pos;
  int                 frame_pos;
  int                 chan_sum;
  int                 open_col;
  int                 col_min;
  int                 col_max;

  column_report_t expected_reports[$];

  int  error_count;
  int  samples_sent;
  int  reports_checked;
  int  reports_predicted;
  int  reg_writes;
  int  hold_count;
  bit  idle_on = 1'b1;
  bit  hold_req;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic int active_channels();
    if (channel_count_reg == 0) return 1;
    return (channel_count_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_count_reg);
  endfunction

  function automatic int column_last_frame(input int col, input int frames);
    longint first_frame;
    longint next_first;
    first_frame = (longint'(col) * frames) / COLUMNS;
    next_first  = (longint'(col + 1) * frames) / COLUMNS;
    return (next_first > first_frame) ? int'(next_first - 1) : int'(first_frame);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic restart_minmax();
    col_min = 32767;
    col_max = -32768;
  endtask

  task automatic predict_columns(input logic signed [SAMPLE_W-1:0] s);
    int             chans;
    int             frames;
    int             cur_frame;
    int             avg;
    bit             first;
    column_report_t r;
    chans  = active_channels();
    frames = (frame_count_reg == 0) ? 1 : int'(frame_count_reg);
    first  = 1'b1;
    chan_sum += s;
    if (chan_pos + 1 < chans) begin
      chan_pos++;
      return;
    end
    avg      = chan_sum / chans;
    chan_sum = 0;
    chan_pos = 0;
    if (avg < col_min) col_min = avg;
    if (avg > col_max) col_max = avg;
    cur_frame = frame_pos;
    while (open_col < COLUMNS &&
           (cur_frame + 1 >= frames || column_last_frame(open_col, frames) <= cur_frame)) begin
      r.column       = open_col[COL_W-1:0];
      r.low_value    = first ? 16'(col_min) : 16'(avg);
      r.high_value   = first ? 16'(col_max) : 16'(avg);
      r.final_column = (open_col == COLUMNS - 1);
      expected_reports = {expected_reports, r};
      reports_predicted++;
      open_col++;
      first = 1'b0;
    end
    if (!first) restart_minmax();
    if (open_col >= COLUMNS) begin
      open_col  = 0;
      frame_pos = 0;
      restart_minmax();
    end else begin
      frame_pos = (frame_pos + 1) & 24'hFFFFFF;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // valid is left high after a transfer so back-to-back samples keep it up
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= s;
    predict_columns(s);
    samples_sent++;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  task automatic settle_block();
    samples_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_FRAME_COUNT) frame_count_reg = FRAME_W'(data);
    else                        channel_count_reg = CHAN_W'(data);
    reg_writes++;
  endtask

  task automatic set_clip(input int frames, input int chans);
    settle_block();
    write_reg(CFG_FRAME_COUNT, frames);
    write_reg(CFG_CHANNEL_COUNT, chans);
  endtask

  // every transfer on the report side is checked against the oldest prediction
  always @(posedge clk) begin
    column_report_t want;
    if (!rst && columns_if.valid && columns_if.ready) begin
      reports_checked++;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report, column", columns_if.column, -1);
      end else begin
        want = expected_reports.pop_front();
        if (columns_if.column !== want.column)
          report_mismatch("column", columns_if.column, want.column);
        if (columns_if.low_value !== want.low_value)
          report_mismatch("low_value", columns_if.low_value, want.low_value);
        if (columns_if.high_value !== want.high_value)
          report_mismatch("high_value", columns_if.high_value, want.high_value);
        if (columns_if.final_column !== want.final_column)
          report_mismatch("final_column", columns_if.final_column, want.final_column);
      end
    end
  end

  // report receiver
  initial begin
    columns_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        columns_if.ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        columns_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        columns_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
  endtask

  task automatic test_channel_average();
    set_clip(64, 3);
    send_sample(-16'sd7);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd5);
    send_sample(16'sd0);
    send_sample(16'sd1);
  endtask

  task automatic test_register_limits();
    set_clip(0, 0);
    send_sample(16'sd1234);
    settle_block();
    write_reg(CFG_CHANNEL_COUNT, 15);
    repeat (8) send_sample(16'sh8000);
  endtask

  task automatic test_channel_drop_mid_frame();
    set_clip(64, 4);
    send_sample(16'sd100);
    send_sample(16'sd200);
    settle_block();
    write_reg(CFG_CHANNEL_COUNT, 2);
    send_sample(16'sd301);
  endtask

  task automatic test_frame_count_change();
    set_clip(24'hFFFFFF, 1);
    repeat (3) send_sample(random_sample());
    settle_block();
    write_reg(CFG_FRAME_COUNT, 2);
    send_sample(random_sample());
  endtask

  task automatic test_random_clips();
    int items;
    int chans;
    int frames;
    int sel;
    int n;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      settle_block();
      case ($urandom_range(0, 9))
        0:       chans = 0;
        1:       chans = $urandom_range(9, 15);
        default: chans = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 11))
        0:       frames = 0;
        1:       frames = $urandom_range(64, 200);
        2:       frames = $urandom_range(1000, 24'hFFFFFF);
        3:       frames = 24'hFFFFFF;
        default: frames = $urandom_range(1, 70);
      endcase
      sel = $urandom_range(0, 3);
      if (sel != 1) write_reg(CFG_FRAME_COUNT, frames);
      if (sel != 0) write_reg(CFG_CHANNEL_COUNT, chans);
      n = $urandom_range(1, 6) * active_channels();
      // partial frame left open for the next setting
      if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 7);
      repeat (n) begin
        send_sample(random_sample());
        items++;
      end
    end
  endtask

  task automatic test_output_backpressure();
    set_clip(2, 1);
    hold_req = 1'b1;
    repeat (12) send_sample(random_sample());
  endtask

  task automatic test_steady_stream();
    settle_block();
    idle_on = 1'b0;
    write_reg(CFG_FRAME_COUNT, 24);
    write_reg(CFG_CHANNEL_COUNT, 2);
    repeat (48) send_sample(random_sample());
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_write_en      <= 1'b0;
    cfg_index         <= CFG_FRAME_COUNT;
    cfg_data          <= '0;
    samples_if.valid  <= 1'b0;
    samples_if.sample <= '0;
    frame_count_reg   = FRAME_COUNT_RST;
    channel_count_reg = CHANNEL_COUNT_RST;
    chan_pos          = 0;
    frame_pos         = 0;
    chan_sum          = 0;
    open_col          = 0;
    restart_minmax();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_channel_average();
    test_register_limits();
    test_channel_drop_mid_frame();
    test_frame_count_change();
    test_random_clips();
    test_output_backpressure();
    test_steady_stream();
    settle_block();

    $display("run: %0d samples sent, %0d of %0d predicted column reports checked, %0d register writes",
             samples_sent, reports_checked, reports_predicted, reg_writes);
    $display("run: averaging, clamped registers, mid-frame and mid-clip changes, long stall");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
